FILE: src/sitoa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitoa_pkg: shared constants for the signed integer to decimal text block
// Word size, character codes, digit budget and the divide-by-ten reciprocal.
// ----------------------------------------------------------------------------
package sitoa_pkg;

    // width of the input field on the port
    localparam int VALUE_W = 32;

    // width of the converted word, sign in the top bit
    localparam int WORD_BITS = 32;

    // output character width
    localparam int CHAR_W = 8;

    // decimal digits needed for a full word magnitude, floor(W * log10(2)) + 1
    localparam int MAX_DIGITS = (WORD_BITS * 30103) / 100000 + 1;

    // digit counter holds 0..MAX_DIGITS, digit index 0..MAX_DIGITS-1
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = $clog2(MAX_DIGITS);

    // one BCD digit
    localparam int DIGIT_W = 4;

    // ascii codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    // reciprocal of ten: ceil(2^(W+4) / 10), quotient is (x * recip) >> (W+4)
    localparam int DIV10_SHIFT = WORD_BITS + 4;
    localparam logic [DIV10_SHIFT:0] DIV10_POW = {1'b1, {DIV10_SHIFT{1'b0}}};
    localparam logic [WORD_BITS:0] DIV10_RECIP =
        (WORD_BITS + 1)'(DIV10_POW / 10 + 1);

endpackage

FILE: src/signed_int_to_decimal_ascii_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top: signed integer to decimal ascii text
// Converts one signed word into a run of characters, last one marked.
// ----------------------------------------------------------------------------
// Each accepted value comes out as its decimal text, most significant
// character first: a '-' for negative values, then the digits without leading
// zeros ("0" for zero), with last high on the final character. The most
// negative value prints through its full magnitude. One value is in flight at
// a time: after the accept cycle the shared divide-by-ten unit produces one
// digit per cycle, then one character per cycle leaves through the output
// register while the output is not stalled. A value of D digits gives D
// characters, plus one for a sign, up to 11 for "-2147483648". in_ready is
// high again as soon as the last character is loaded into the output register.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [sitoa_pkg::VALUE_W-1:0] value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sitoa_pkg::CHAR_W-1:0]        character,
    output logic                                last
);

    localparam int W = sitoa_pkg::WORD_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                      state_reg, state_next;
    logic [sitoa_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                            neg_reg, neg_next;
    logic                            out_valid_reg, out_valid_next;
    logic [W-1:0]                    mag_reg;
    logic [sitoa_pkg::DIGIT_W-1:0]   digit_reg [sitoa_pkg::MAX_DIGITS];
    logic [sitoa_pkg::CHAR_W-1:0]    character_reg;
    logic                            last_reg;

    logic                            accept_in;
    logic                            out_slot;
    logic                            emit;
    logic [W-1:0]                    word;
    logic [W-1:0]                    word_mag;
    logic [W-1:0]                    quot;
    logic [sitoa_pkg::DIGIT_W-1:0]   rem;
    logic [sitoa_pkg::CNT_W-1:0]     rd_cnt;
    logic [sitoa_pkg::DIGIT_W-1:0]   rd_digit;

    // handshake
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept_in = in_valid && in_ready;
    assign out_slot  = !out_valid_reg || out_ready;
    assign emit      = (state_reg == ST_EMIT) && out_slot;

    // input word and its unsigned magnitude
    assign word     = W'(value);
    assign word_mag = word[W-1] ? (~word + W'(1)) : word;

    // shared divide-by-ten unit
    sitoa_div10 u_div10 (
        .dividend  (mag_reg),
        .quotient  (quot),
        .remainder (rem)
    );

    // digit stack read, most significant digit sits at the top
    assign rd_cnt   = cnt_reg - sitoa_pkg::CNT_W'(1);
    assign rd_digit = digit_reg[rd_cnt[sitoa_pkg::IDX_W-1:0]];

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    neg_next   = word[W-1];
                    cnt_next   = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cnt_next = cnt_reg + sitoa_pkg::CNT_W'(1);
                if (quot == '0)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_slot)
                begin
                    if (neg_reg)
                    begin
                        neg_next = 1'b0;
                    end
                    else
                    begin
                        cnt_next = rd_cnt;
                        if (cnt_reg == sitoa_pkg::CNT_W'(1))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output beat valid
    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            neg_reg       <= neg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // magnitude and digit stack
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            mag_reg <= word_mag;
        end
        else if (state_reg == ST_CONV)
        begin
            mag_reg <= quot;
            digit_reg[cnt_reg[sitoa_pkg::IDX_W-1:0]] <= rem;
        end
    end

    // output beat payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            if (neg_reg)
            begin
                character_reg <= sitoa_pkg::CHAR_MINUS;
                last_reg      <= 1'b0;
            end
            else
            begin
                character_reg <= sitoa_pkg::CHAR_ZERO
                                 + sitoa_pkg::CHAR_W'(rd_digit);
                last_reg      <= (cnt_reg == sitoa_pkg::CNT_W'(1));
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign character = character_reg;
    assign last      = last_reg;

endmodule

FILE: src/sitoa_div10.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitoa_div10: divide-by-ten unit
// Quotient through a reciprocal multiply, remainder from the low nibble.
// ----------------------------------------------------------------------------
module sitoa_div10 (
    input  logic [sitoa_pkg::WORD_BITS-1:0] dividend,
    output logic [sitoa_pkg::WORD_BITS-1:0] quotient,
    output logic [sitoa_pkg::DIGIT_W-1:0]   remainder
);

    localparam int PROD_W = 2 * sitoa_pkg::WORD_BITS + 1;

    logic [PROD_W-1:0]                prod;
    logic [sitoa_pkg::DIGIT_W-1:0]    q_lo;
    logic [sitoa_pkg::DIGIT_W-1:0]    d_lo;

    // reciprocal multiply, then drop the fraction bits
    assign prod     = PROD_W'(dividend) * PROD_W'(sitoa_pkg::DIV10_RECIP);
    assign quotient = sitoa_pkg::WORD_BITS'(prod >> sitoa_pkg::DIV10_SHIFT);

    // remainder is below 16, so x - 10q is exact modulo 16
    assign q_lo      = quotient[sitoa_pkg::DIGIT_W-1:0];
    assign d_lo      = dividend[sitoa_pkg::DIGIT_W-1:0];
    assign remainder = d_lo - {q_lo[0], 3'b000} - {q_lo[2:0], 1'b0};

endmodule

FILE: src/sitoa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitoa_checker: port-level checks for the decimal text converter
// Watches the top level ports and flags bad beats or sequencing.
// ----------------------------------------------------------------------------
module sitoa_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [sitoa_pkg::CHAR_W-1:0]        character,
    input  logic                                last
);

    // a stalled output beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(character) && $stable(last))
    else $error("output beat changed while stalled");

    // only a sign or a decimal digit leaves
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (character == sitoa_pkg::CHAR_MINUS)
                      || (character >= sitoa_pkg::CHAR_ZERO
                          && character <= sitoa_pkg::CHAR_NINE))
    else $error("output character is not a sign or a digit");

    // a sign is never marked as the last character
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (character == sitoa_pkg::CHAR_MINUS) |-> !last)
    else $error("sign marked as last character");

    // one value at a time: no accept right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted value");

endmodule

bind signed_int_to_decimal_ascii_top sitoa_checker u_sitoa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .character (character),
    .last      (last)
);

FILE: verif/sitoa_text_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitoa_text_checker: scoreboard for the signed integer to decimal text block
// Watches both channels, predicts the text of every accepted value and
// compares each output beat with the oldest predicted character.
// ----------------------------------------------------------------------------
module sitoa_text_checker
    import sitoa_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic signed [VALUE_W-1:0]  value,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [CHAR_W-1:0]          character,
    input  logic                       last,
    output int                         errors,
    output int                         pending
);

    localparam int RADIX    = 10;
    localparam int TEXT_MAX = 24;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } text_char_t;

    // characters still owed by the block, oldest first
    text_char_t expected_text[$];

    // decimal text of one value: sign, then digits without leading zeros
    function automatic void predict_text(input logic [VALUE_W-1:0] v);
        logic [WORD_BITS-1:0] word;
        logic [WORD_BITS-1:0] mag;
        logic [CHAR_W-1:0]    digits [TEXT_MAX];
        int                   nd;
        text_char_t           c;
        word = v[WORD_BITS-1:0];
        mag  = word[WORD_BITS-1] ? -word : word;
        nd   = 0;
        // least significant digit first
        do
        begin
            digits[nd] = CHAR_ZERO + CHAR_W'(mag % RADIX);
            mag = mag / RADIX;
            nd++;
        end
        while (mag != 0 && nd < TEXT_MAX);
        if (word[WORD_BITS-1])
        begin
            c.character = CHAR_MINUS;
            c.last      = 1'b0;
            expected_text.push_back(c);
        end
        for (int k = nd - 1; k >= 0; k--)
        begin
            c.character = digits[k];
            c.last      = (k == 0);
            expected_text.push_back(c);
        end
    endfunction

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    // compare output beats, then queue the text of an accepted value
    always @(posedge clk)
    begin
        text_char_t exp_char;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_text.size() == 0)
                begin
                    $error("character: expected none, actual %h (last %b)", character, last);
                    errors++;
                end
                else
                begin
                    exp_char = expected_text.pop_front();
                    if (character !== exp_char.character)
                    begin
                        $error("character: expected %h, actual %h",
                               exp_char.character, character);
                        errors++;
                    end
                    if (last !== exp_char.last)
                    begin
                        $error("last: expected %b, actual %b", exp_char.last, last);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
                predict_text(value);
            pending = expected_text.size();
        end
    end

endmodule

FILE: verif/signed_int_to_decimal_ascii_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top_test: testbench for the decimal text block
// Drives directed and random signed values with random idling on both sides;
// the checker predicts each character and the top gives the verdict.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top_test;
    import sitoa_pkg::*;

    localparam int RANDOM_VALUES = 370;
    localparam int CALM_VALUES   = 60;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic signed [VALUE_W-1:0] value;
    logic                      out_valid;
    logic                      out_ready;
    logic [CHAR_W-1:0]         character;
    logic                      last;
    int                        errors;
    int                        pending;

    // no idling on either side once set
    logic                      calm;

    signed_int_to_decimal_ascii_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .character (character),
        .last      (last)
    );

    sitoa_text_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .character (character),
        .last      (last),
        .errors    (errors),
        .pending   (pending)
    );

    // clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // hard limit on the run
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // output side stalls in random bursts
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // present one beat, with an optional idle burst ahead of it
    task automatic send_value(input logic [VALUE_W-1:0] v);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
    endtask

    // random value, spread evenly over digit counts, some fully random words
    function automatic logic [VALUE_W-1:0] random_value();
        longint lo;
        longint hi;
        longint mag;
        int     nd;
        if ($urandom_range(0, 4) == 0)
            return VALUE_W'($urandom);
        nd = $urandom_range(1, 10);
        lo = 1;
        for (int k = 1; k < nd; k++)
            lo = lo * 10;
        hi = lo * 10 - 1;
        if (nd == 1)
            lo = 0;
        if (hi > 64'sd2147483647)
            hi = 64'sd2147483647;
        mag = lo + longint'($urandom) % (hi - lo + 1);
        if ($urandom_range(0, 1) == 1)
            mag = -mag;
        return VALUE_W'(mag);
    endfunction

    // stimulus and verdict
    initial
    begin
        logic [VALUE_W-1:0] directed [$];
        rst_n    = 1'b0;
        in_valid = 1'b0;
        value    = '0;
        calm     = 1'b0;
        directed = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10,
                     32'sd99, 32'sd100, -32'sd101, 32'sd2147483647, 32'h8000_0000,
                     -32'sd2147483647, 32'sd1000000000, -32'sd1000000000,
                     32'sd999999999, 32'sd1234567890, 32'h5555_5555, 32'hAAAA_AAAA,
                     32'sd7, 32'sd0};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes and special cases
        foreach (directed[i])
            send_value(directed[i]);

        // random values, idling stops for the last stretch
        for (int i = 0; i < RANDOM_VALUES; i++)
        begin
            if (i == RANDOM_VALUES - CALM_VALUES)
                calm = 1'b1;
            send_value(random_value());
        end
        in_valid <= 1'b0;
        @(posedge clk);

        // drain, then allow for stray beats
        wait (pending == 0);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
